FILE: rtl/sd_host_clock_divisor_unit_defines.svh
// Assertion macros for the SD host clock divisor unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SD_HOST_CLOCK_DIVISOR_UNIT_DEFINES_SVH
`define SD_HOST_CLOCK_DIVISOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SDCD_ASSERT_SAME(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define SDCD_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SDCD_ASSERT_SAME(name, pre, post, msg)
`define SDCD_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

FILE: rtl/sdcd_pkg.sv
// Types, constants and datapath functions for the SD host clock divisor unit.
// No dependencies.
package sdcd_pkg;

    localparam int DIV_W          = 30;
    localparam int VER_W          = 8;
    localparam int FIELD_W        = 16;
    localparam int SHIFT_W        = 3;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = DIV_W / BITS_PER_STAGE;

    localparam logic [DIV_W-1:0]   BASE_RESET_HZ = 30'd41666666;
    localparam logic [VER_W-1:0]   SPEC_V2       = 8'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX     = 3'd7;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvd;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] dsr;
        logic             newer;
        logic             zero;
    } stage_t;

    typedef struct packed {
        logic [FIELD_W-1:0] clock_field;
        logic [DIV_W-1:0]   divisor_used;
        logic [SHIFT_W-1:0] shift_used;
        logic               divide_error;
    } result_t;

    // Restoring division, BITS_PER_STAGE quotient bits per call.
    function automatic stage_t div_step(input stage_t s);
        stage_t         r;
        logic [DIV_W:0] t;
        r = s;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            t = {r.rem, r.dvd[DIV_W-1]};
            r.dvd = {r.dvd[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, r.dsr})
            begin
                t = t - {1'b0, r.dsr};
                r.quo = {r.quo[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r.quo = {r.quo[DIV_W-2:0], 1'b0};
            end
            r.rem = t[DIV_W-1:0];
        end
        return r;
    endfunction

    function automatic result_t finish(input stage_t s);
        result_t            r;
        logic [DIV_W-1:0]   c;
        logic [DIV_W-1:0]   x;
        logic [DIV_W-1:0]   d;
        logic [SHIFT_W-1:0] sh;
        c  = s.quo;
        x  = c - 30'd1;
        sh = '0;
        if (c == '0 || x[DIV_W-1:8] != '0)
        begin
            sh = SHIFT_MAX;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (x[i])
                    sh = SHIFT_W'(i);
            end
        end
        d = s.newer ? c : (30'd1 << sh);
        if (d <= 30'd2)
        begin
            d  = 30'd2;
            sh = '0;
        end
        r.clock_field  = {d[7:0], (s.newer ? d[9:8] : 2'b00), 6'b0};
        r.divisor_used = d;
        r.shift_used   = sh;
        r.divide_error = 1'b0;
        if (s.zero)
            r = '{clock_field: '0, divisor_used: '0, shift_used: '0, divide_error: 1'b1};
        return r;
    endfunction

endpackage

FILE: rtl/sdcd_if.sv
// Channel interfaces for the SD host clock divisor unit.
// Depends on sdcd_pkg for field widths.
interface sdcd_req_if;
    import sdcd_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIV_W-1:0]   target_freq_hz;
    logic [VER_W-1:0]   host_version;
    modport source (output valid, target_freq_hz, host_version, input ready);
    modport sink   (input valid, target_freq_hz, host_version, output ready);
endinterface

interface sdcd_rsp_if;
    import sdcd_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] clock_field;
    logic [DIV_W-1:0]   divisor_used;
    logic [SHIFT_W-1:0] shift_used;
    logic               divide_error;
    modport source (output valid, clock_field, divisor_used, shift_used, divide_error,
                    input ready);
    modport sink   (input valid, clock_field, divisor_used, shift_used, divide_error,
                    output ready);
endinterface

interface sdcd_cfg_if;
    import sdcd_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIV_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/sd_host_clock_divisor_unit.sv
// SD host clock divisor unit: top level with the pipelined divider.
// Depends on sdcd_pkg, the channel interfaces and the assertion macro header.
//
// Accepts one item per cycle while the output side does not stall, and returns one
// result per item, in order, from the output register. The quotient
// base_clock_hz / target_freq_hz comes from a 15-stage restoring divider that
// resolves two quotient bits per stage; a final stage derives the divisor, shift
// and packed clock field into the output register. Every stage holds its item
// under backpressure and empty stages fill, so a stall loses nothing. The base
// clock register (reset 41666666) is written through cfg, always ready.
`include "sd_host_clock_divisor_unit_defines.svh"

module sd_host_clock_divisor_unit
    import sdcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sdcd_cfg_if.sink   cfg,
    sdcd_req_if.sink   req,
    sdcd_rsp_if.source rsp
);

    logic [DIV_W-1:0] base_clock_reg;
    stage_t           st_reg  [0:DIV_STAGES];
    logic             vld_reg [0:DIV_STAGES];
    logic             rdy     [0:DIV_STAGES+1];
    result_t          out_reg;
    result_t          out_next;
    logic             out_vld_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_clock_reg <= BASE_RESET_HZ;
        else if (cfg.valid)
            base_clock_reg <= cfg.data;
    end

    // per-stage ready: a stage moves when empty or when the next one moves
    assign rdy[DIV_STAGES+1] = !out_vld_reg || rsp.ready;
    genvar g;
    generate
        for (g = 0; g <= DIV_STAGES; g++)
        begin : g_rdy
            assign rdy[g] = !vld_reg[g] || rdy[g+1];
        end
    endgenerate

    assign req.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (rdy[0])
            vld_reg[0] <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && req.valid)
        begin
            st_reg[0].rem   <= '0;
            st_reg[0].dvd   <= base_clock_reg;
            st_reg[0].quo   <= '0;
            st_reg[0].dsr   <= req.target_freq_hz;
            st_reg[0].newer <= req.host_version > SPEC_V2;
            st_reg[0].zero  <= req.target_freq_hz == '0;
        end
    end

    generate
        for (g = 1; g <= DIV_STAGES; g++)
        begin : g_div
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else if (rdy[g])
                    vld_reg[g] <= vld_reg[g-1];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[g] && vld_reg[g-1])
                    st_reg[g] <= div_step(st_reg[g-1]);
            end
        end
    endgenerate

    assign out_next = finish(st_reg[DIV_STAGES]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (rdy[DIV_STAGES+1])
            out_vld_reg <= vld_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[DIV_STAGES+1] && vld_reg[DIV_STAGES])
            out_reg <= out_next;
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.clock_field  = out_reg.clock_field;
    assign rsp.divisor_used = out_reg.divisor_used;
    assign rsp.shift_used   = out_reg.shift_used;
    assign rsp.divide_error = out_reg.divide_error;

    `SDCD_ASSERT_SAME(a_err_zero, rsp.valid && rsp.divide_error, rsp.clock_field == '0 && rsp.divisor_used == '0 && rsp.shift_used == '0, "error item carries nonzero fields")
    `SDCD_ASSERT_SAME(a_div_min, rsp.valid && !rsp.divide_error, rsp.divisor_used >= 30'd2, "divisor below two")
    `SDCD_ASSERT_SAME(a_full_stall, !req.ready, rsp.valid && !rsp.ready, "input stalled with room in pipeline")
    `SDCD_ASSERT_NEXT(a_enter, req.valid && req.ready, vld_reg[0], "accepted item missing from first stage")

endmodule

FILE: tb/sd_host_clock_divisor_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sd_host_clock_divisor_unit: directed and random requests
// under several base clock settings, with results compared against a local predictor or fixed expected values.
// Depends on sdcd_pkg, the sdcd channel interfaces and the top level of the block.
module sd_host_clock_divisor_unit_tb;
    import sdcd_pkg::*;

    typedef struct {
        logic [DIV_W-1:0] freq;
        logic [VER_W-1:0] ver;
        bit               typed;
        result_t          want;
    } row_t;

    localparam result_t ZERO_FREQ  = '{16'h0000, 30'd0, 3'd0, 1'b1};
    localparam result_t FORCED_TWO = '{16'h0200, 30'd2, 3'd0, 1'b0};
    localparam result_t OLD_MAX    = '{16'h8000, 30'd128, 3'd7, 1'b0};
    localparam int      DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;

    sdcd_cfg_if cfg_ch ();
    sdcd_req_if req_ch ();
    sdcd_rsp_if rsp_ch ();

    sd_host_clock_divisor_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    logic [DIV_W-1:0] base_hz;
    result_t          expected_results[$];
    int               mismatch_count = 0;
    int               result_count = 0;
    logic [15:0]      ready_pattern = 16'hFFFF;
    int               pattern_age = 0;

    function automatic result_t clock_divisor_of(input logic [DIV_W-1:0] base,
                                                 input logic [DIV_W-1:0] f,
                                                 input logic [VER_W-1:0] v);
        result_t     r;
        logic [31:0] c;
        logic [31:0] x;
        logic [31:0] d;
        int unsigned s;
        bit          newer;
        r = '0;
        if (f == '0)
        begin
            r.divide_error = 1'b1;
            return r;
        end
        newer = v > SPEC_V2;
        c = {2'b00, base} / {2'b00, f};
        x = c - 32'd1;
        s = 0;
        if (x != 32'd0)
        begin
            for (int i = 0; i < 32; i++)
            begin
                if (x[i])
                    s = i;
            end
            if (s > 7)
                s = 7;
        end
        d = newer ? c : (32'd1 << s);
        if (d <= 32'd2)
        begin
            d = 32'd2;
            s = 0;
        end
        r.clock_field = {d[7:0], 8'h00};
        if (newer)
            r.clock_field[7:6] = d[9:8];
        r.divisor_used = d[DIV_W-1:0];
        r.shift_used   = s[2:0];
        return r;
    endfunction

    function automatic row_t dir_row(input logic [DIV_W-1:0] f, input logic [VER_W-1:0] v,
                                     input bit typed = 1'b0, input result_t want = '0);
        row_t r;
        r.freq  = f;
        r.ver   = v;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [DIV_W-1:0] pick_freq(input logic [DIV_W-1:0] base);
        int unsigned kind;
        int unsigned f;
        kind = $urandom_range(0, 15);
        if (kind == 0)
            f = 0;
        else if (kind <= 6)
        begin
            f = base / $urandom_range(1, 1100);
            if (f == 0)
                f = $urandom_range(1, 1000);
            else if (f < 1000000000)
                f = f + $urandom_range(0, 1);
        end
        else if (kind <= 9)
        begin
            f = base / $urandom_range(1, 4);
            if (f == 0)
                f = 1;
        end
        else if (kind <= 13)
            f = $urandom_range(1, 1000000000);
        else if (kind == 14)
            f = $urandom_range(1, 1000);
        else
        begin
            f = base + $urandom_range(1, 1000);
            if (f > 1000000000)
                f = 1000000000;
        end
        return f[DIV_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH result %0d: %s", result_count, what);
        mismatch_count++;
    endtask

    // Receiver: rotating ready pattern, reloaded now and then; all-ones gives stall-free runs.
    always @(posedge clk)
    begin
        if (pattern_age == 0)
        begin
            pattern_age   <= $urandom_range(20, 120);
            ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                          : (16'($urandom) | 16'h0001);
            rsp_ch.ready  <= 1'b1;
        end
        else
        begin
            pattern_age   <= pattern_age - 1;
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            rsp_ch.ready  <= ready_pattern[15];
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("item with no request outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.clock_field !== want.clock_field)
                    report_mismatch($sformatf("clock_field: got 0x%0h expected 0x%0h",
                                              rsp_ch.clock_field, want.clock_field));
                if (rsp_ch.divisor_used !== want.divisor_used)
                    report_mismatch($sformatf("divisor_used: got 0x%0h expected 0x%0h",
                                              rsp_ch.divisor_used, want.divisor_used));
                if (rsp_ch.shift_used !== want.shift_used)
                    report_mismatch($sformatf("shift_used: got 0x%0h expected 0x%0h",
                                              rsp_ch.shift_used, want.shift_used));
                if (rsp_ch.divide_error !== want.divide_error)
                    report_mismatch($sformatf("divide_error: got 0x%0h expected 0x%0h",
                                              rsp_ch.divide_error, want.divide_error));
            end
            result_count++;
        end
    end

    task automatic send_req(input logic [DIV_W-1:0] f, input logic [VER_W-1:0] v,
                            input bit typed = 1'b0, input result_t want = '0);
        req_ch.valid          <= 1'b1;
        req_ch.target_freq_hz <= f;
        req_ch.host_version   <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_results.push_back(typed ? want : clock_divisor_of(base_hz, f, v));
    endtask

    task automatic idle_gap(input int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [DIV_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        base_hz = value;
    endtask

    task automatic run_random(input int n);
        int burst;
        logic [VER_W-1:0] v;
        burst = 0;
        repeat (n)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 6));
            end
            burst--;
            v = ($urandom_range(0, 1) == 0) ? VER_W'($urandom_range(0, 3))
                                            : VER_W'($urandom_range(0, 255));
            send_req(pick_freq(base_hz), v);
        end
    endtask

    initial
    begin
        row_t             rows[$];
        logic [DIV_W-1:0] phase_bases[$];
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.target_freq_hz = '0;
        req_ch.host_version   = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = '0;
        rsp_ch.ready          = 1'b0;
        base_hz               = BASE_RESET_HZ;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            dir_row(30'd0, 8'd0, 1'b1, ZERO_FREQ),
            dir_row(30'd0, 8'd2, 1'b1, ZERO_FREQ),
            dir_row(30'd0, 8'd255, 1'b1, ZERO_FREQ),
            dir_row(30'd1000000000, 8'd0, 1'b1, OLD_MAX),
            dir_row(30'd1000000000, 8'd2, 1'b1, FORCED_TWO),
            dir_row(30'd41666666, 8'd0, 1'b1, FORCED_TWO),
            dir_row(30'd41666666, 8'd1, 1'b1, FORCED_TWO),
            dir_row(30'd41666666, 8'd3, 1'b1, FORCED_TWO),
            dir_row(30'd1, 8'd0, 1'b1, OLD_MAX),
            dir_row(30'd1, 8'd2),
            dir_row(30'd1, 8'd255),
            dir_row(30'd400000, 8'd0),
            dir_row(30'd400000, 8'd2),
            dir_row(30'd20833333, 8'd0),
            dir_row(30'd13888888, 8'd0),
            dir_row(30'd13888888, 8'd2),
            dir_row(30'd10416666, 8'd2),
            dir_row(30'd162760, 8'd2),
            dir_row(30'd40690, 8'd2),
            dir_row(30'd40730, 8'd2),
            dir_row(30'd325520, 8'd0),
            dir_row(30'd325521, 8'd1),
            dir_row(30'd536870912, 8'd7),
            dir_row(30'h15555555, 8'hAA),
            dir_row(30'h2AAAAAAA, 8'h55)
        };
        foreach (rows[i])
            send_req(rows[i].freq, rows[i].ver, rows[i].typed, rows[i].want);
        run_random(80);

        phase_bases = '{30'd1000000000, 30'd1, 30'd0,
                        30'($urandom_range(1, 1000000000)),
                        30'($urandom_range(1, 1000000000)),
                        30'd100000000, BASE_RESET_HZ};
        foreach (phase_bases[i])
        begin
            wait_drained();
            write_base(phase_bases[i]);
            run_random(80);
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4_800_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
